// ===== rtl/core/qenc_pkg.sv =====
// ----------------------------------------------------------------------------
// qenc_pkg
// shared constants and types of the quadrature encoder step counter
// ----------------------------------------------------------------------------
package qenc_pkg;

   localparam int TIME_BITS_DEFAULT  = 32;
   localparam int COUNT_BITS_DEFAULT = 16;

   localparam int DEBOUNCE_BITS = 8;
   localparam int HOLDOFF_BITS  = 32;
   localparam int STEP_BITS     = 7;

   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = 32;

   localparam logic [CSR_INDEX_BITS-1:0] REG_DEBOUNCE_COUNT  = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_REVERSE_HOLDOFF = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] REG_STEP_SIZE       = 2'd2;

   localparam logic [DEBOUNCE_BITS-1:0] DEBOUNCE_RESET = 8'd1;
   localparam logic [HOLDOFF_BITS-1:0]  HOLDOFF_RESET  = 32'd100;
   localparam logic [STEP_BITS-1:0]     STEP_RESET     = 7'd1;

   localparam logic OP_SAMPLE = 1'b0;
   localparam logic OP_READ   = 1'b1;

   localparam logic signed [1:0] DIR_NONE    = 2'sb00;
   localparam logic signed [1:0] DIR_FORWARD = 2'sb01;
   localparam logic signed [1:0] DIR_REVERSE = 2'sb11;

   typedef struct packed {
      logic [DEBOUNCE_BITS-1:0] debounce_count;
      logic [HOLDOFF_BITS-1:0]  reverse_holdoff;
      logic [STEP_BITS-1:0]     step_size;
   } cfg_type;

   typedef struct packed {
      logic                     primed;
      logic                     level_a;
      logic                     level_b;
      logic [DEBOUNCE_BITS-1:0] mismatch_a;
      logic [DEBOUNCE_BITS-1:0] mismatch_b;
   } pins_type;

endpackage

// ===== rtl/core/qenc_req_if.sv =====
// ----------------------------------------------------------------------------
// qenc_req_if
// request channel: pin samples and read commands
// ----------------------------------------------------------------------------
interface qenc_req_if #(
   parameter int TIME_BITS = qenc_pkg::TIME_BITS_DEFAULT
);
   logic                 valid;
   logic                 ready;
   logic                 operation;
   logic                 pin_a;
   logic                 pin_b;
   logic [TIME_BITS-1:0] now_time;

   modport source (output valid, operation, pin_a, pin_b, now_time, input ready);
   modport sink   (input valid, operation, pin_a, pin_b, now_time, output ready);
endinterface

// ===== rtl/core/qenc_rsp_if.sv =====
// ----------------------------------------------------------------------------
// qenc_rsp_if
// response channel: step direction and read count
// ----------------------------------------------------------------------------
interface qenc_rsp_if #(
   parameter int COUNT_BITS = qenc_pkg::COUNT_BITS_DEFAULT
);
   logic                         valid;
   logic                         ready;
   logic signed [1:0]            step_taken;
   logic signed [COUNT_BITS-1:0] moves;

   modport source (output valid, step_taken, moves, input ready);
   modport sink   (input valid, step_taken, moves, output ready);
endinterface

// ===== rtl/core/qenc_csr_if.sv =====
// ----------------------------------------------------------------------------
// qenc_csr_if
// register write channel
// ----------------------------------------------------------------------------
interface qenc_csr_if;
   logic                                valid;
   logic                                ready;
   logic [qenc_pkg::CSR_INDEX_BITS-1:0] index;
   logic [qenc_pkg::CSR_DATA_BITS-1:0]  data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/core/qenc_step_logic.sv =====
// ----------------------------------------------------------------------------
// qenc_step_logic
// debounce, direction decision with hold-off, saturating count update and count read with clear
// ----------------------------------------------------------------------------
module qenc_step_logic #(
   parameter int TIME_BITS  = qenc_pkg::TIME_BITS_DEFAULT,
   parameter int COUNT_BITS = qenc_pkg::COUNT_BITS_DEFAULT
) (
   input  qenc_pkg::cfg_type             cfg,
   input  logic                          operation,
   input  logic                          pin_a,
   input  logic                          pin_b,
   input  logic [TIME_BITS-1:0]          now_time,
   input  qenc_pkg::pins_type            pins,
   input  logic [TIME_BITS-1:0]          last_fwd,
   input  logic [TIME_BITS-1:0]          last_rev,
   input  logic signed [COUNT_BITS-1:0]  acc,
   output qenc_pkg::pins_type            pins_next,
   output logic [TIME_BITS-1:0]          last_fwd_next,
   output logic [TIME_BITS-1:0]          last_rev_next,
   output logic signed [COUNT_BITS-1:0]  acc_next,
   output logic signed [1:0]             step_taken,
   output logic signed [COUNT_BITS-1:0]  moves
);

   localparam int CMP_BITS = (TIME_BITS > qenc_pkg::HOLDOFF_BITS) ?
                             TIME_BITS : qenc_pkg::HOLDOFF_BITS;
   localparam logic signed [COUNT_BITS:0] SUM_MAX =
      (COUNT_BITS+1)'((64'd1 << (COUNT_BITS-1)) - 64'd1);
   localparam logic signed [COUNT_BITS:0] SUM_MIN = -SUM_MAX;

   logic [qenc_pkg::DEBOUNCE_BITS-1:0] mis_a_inc;
   logic [qenc_pkg::DEBOUNCE_BITS-1:0] mis_b_inc;
   logic                               a_diff;
   logic                               b_diff;
   logic                               a_commit;
   logic                               b_commit;
   logic                               a_step;
   logic                               b_step;
   logic [TIME_BITS-1:0]               fwd_eff;
   logic [TIME_BITS-1:0]               since_rev;
   logic [TIME_BITS-1:0]               since_fwd;
   logic [CMP_BITS-1:0]                holdoff_ext;
   logic signed [COUNT_BITS:0]         acc_ext;
   logic signed [COUNT_BITS:0]         step_ext;
   logic signed [COUNT_BITS:0]         sum;
   logic signed [COUNT_BITS:0]         sum_sat;

   assign a_diff      = pins.level_a != pin_a;
   assign b_diff      = pins.level_b != pin_b;
   assign mis_a_inc   = pins.mismatch_a + 1'b1;
   assign mis_b_inc   = pins.mismatch_b + 1'b1;
   assign a_commit    = a_diff && (mis_a_inc >= cfg.debounce_count);
   assign b_commit    = b_diff && (mis_b_inc > cfg.debounce_count);
   assign holdoff_ext = CMP_BITS'(cfg.reverse_holdoff);
   assign since_rev   = now_time - last_rev;
   assign a_step      = a_commit && (pin_a == pin_b) &&
                        (CMP_BITS'(since_rev) >= holdoff_ext);
   assign fwd_eff     = a_step ? now_time : last_fwd;
   assign since_fwd   = now_time - fwd_eff;
   assign b_step      = b_commit && (pin_a == pin_b) &&
                        (CMP_BITS'(since_fwd) >= holdoff_ext);

   assign acc_ext  = (COUNT_BITS+1)'(acc);
   assign step_ext = signed'((COUNT_BITS+1)'(cfg.step_size));
   assign sum      = b_step ? (acc_ext - step_ext) : (acc_ext + step_ext);

   always_comb begin
      if (sum > SUM_MAX) begin
         sum_sat = SUM_MAX;
      end else if (sum < SUM_MIN) begin
         sum_sat = SUM_MIN;
      end else begin
         sum_sat = sum;
      end
   end

   always_comb begin
      pins_next     = pins;
      last_fwd_next = last_fwd;
      last_rev_next = last_rev;
      acc_next      = acc;
      step_taken    = qenc_pkg::DIR_NONE;
      moves         = '0;
      if (operation == qenc_pkg::OP_READ) begin
         moves    = acc;
         acc_next = '0;
      end else if (!pins.primed) begin
         pins_next.primed  = 1'b1;
         pins_next.level_a = pin_a;
         pins_next.level_b = pin_b;
      end else begin
         pins_next.mismatch_a = (a_diff && !a_commit) ? mis_a_inc : '0;
         pins_next.mismatch_b = (b_diff && !b_commit) ? mis_b_inc : '0;
         if (a_commit) begin
            pins_next.level_a = pin_a;
         end
         if (b_commit) begin
            pins_next.level_b = pin_b;
         end
         last_fwd_next = fwd_eff;
         if (b_step) begin
            last_rev_next = now_time;
            step_taken    = qenc_pkg::DIR_REVERSE;
         end else if (a_step) begin
            step_taken    = qenc_pkg::DIR_FORWARD;
         end
         if (a_step || b_step) begin
            acc_next = sum_sat[COUNT_BITS-1:0];
         end
      end
   end

endmodule

// ===== rtl/core/quadrature_encoder_step_counter_unit.sv =====
// ----------------------------------------------------------------------------
// quadrature_encoder_step_counter_unit
// path: a request passes the input register, then the result register, before its
// response is valid and can transfer
// throughput: one request per cycle, stalled only by response back-pressure
// reset: synchronous; clears count, pin levels, debounce counters and step times,
// registers return to debounce 1, hold-off 100, step size 1
// ----------------------------------------------------------------------------
module quadrature_encoder_step_counter_unit #(
   parameter int TIME_BITS  = qenc_pkg::TIME_BITS_DEFAULT,
   parameter int COUNT_BITS = qenc_pkg::COUNT_BITS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   qenc_req_if.sink    req_chan,
   qenc_rsp_if.source  rsp_chan,
   qenc_csr_if.sink    csr_chan
);

   // configuration registers
   qenc_pkg::cfg_type cfg_ff;
   qenc_pkg::cfg_type cfg_in;

   // input stage
   logic                 in_valid_ff;
   logic                 op_ff;
   logic                 pin_a_ff;
   logic                 pin_b_ff;
   logic [TIME_BITS-1:0] now_ff;

   // encoder state
   qenc_pkg::pins_type           pins_ff;
   qenc_pkg::pins_type           pins_in;
   logic [TIME_BITS-1:0]         last_fwd_ff;
   logic [TIME_BITS-1:0]         last_fwd_in;
   logic [TIME_BITS-1:0]         last_rev_ff;
   logic [TIME_BITS-1:0]         last_rev_in;
   logic signed [COUNT_BITS-1:0] acc_ff;
   logic signed [COUNT_BITS-1:0] acc_in;

   // result stage
   logic                         rsp_valid_ff;
   logic signed [1:0]            step_ff;
   logic signed [1:0]            step_in;
   logic signed [COUNT_BITS-1:0] moves_ff;
   logic signed [COUNT_BITS-1:0] moves_in;

   logic advance;
   logic req_xfer;

   assign advance  = in_valid_ff && (!rsp_valid_ff || rsp_chan.ready);
   assign req_xfer = req_chan.valid && req_chan.ready;

   assign req_chan.ready   = !in_valid_ff || advance;
   assign csr_chan.ready   = 1'b1;
   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.step_taken = step_ff;
   assign rsp_chan.moves      = moves_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_chan.valid) begin
         unique case (csr_chan.index)
            qenc_pkg::REG_DEBOUNCE_COUNT:
               cfg_in.debounce_count  = csr_chan.data[qenc_pkg::DEBOUNCE_BITS-1:0];
            qenc_pkg::REG_REVERSE_HOLDOFF:
               cfg_in.reverse_holdoff = csr_chan.data[qenc_pkg::HOLDOFF_BITS-1:0];
            qenc_pkg::REG_STEP_SIZE:
               cfg_in.step_size       = csr_chan.data[qenc_pkg::STEP_BITS-1:0];
            default: ;
         endcase
      end
   end

   qenc_step_logic #(
      .TIME_BITS  (TIME_BITS),
      .COUNT_BITS (COUNT_BITS)
   ) u_step_logic (
      .cfg           (cfg_ff),
      .operation     (op_ff),
      .pin_a         (pin_a_ff),
      .pin_b         (pin_b_ff),
      .now_time      (now_ff),
      .pins          (pins_ff),
      .last_fwd      (last_fwd_ff),
      .last_rev      (last_rev_ff),
      .acc           (acc_ff),
      .pins_next     (pins_in),
      .last_fwd_next (last_fwd_in),
      .last_rev_next (last_rev_in),
      .acc_next      (acc_in),
      .step_taken    (step_in),
      .moves         (moves_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.debounce_count  <= qenc_pkg::DEBOUNCE_RESET;
         cfg_ff.reverse_holdoff <= qenc_pkg::HOLDOFF_RESET;
         cfg_ff.step_size       <= qenc_pkg::STEP_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_chan.ready) begin
         in_valid_ff <= req_chan.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         op_ff    <= req_chan.operation;
         pin_a_ff <= req_chan.pin_a;
         pin_b_ff <= req_chan.pin_b;
         now_ff   <= req_chan.now_time;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pins_ff     <= '0;
         last_fwd_ff <= '0;
         last_rev_ff <= '0;
         acc_ff      <= '0;
      end else if (advance) begin
         pins_ff     <= pins_in;
         last_fwd_ff <= last_fwd_in;
         last_rev_ff <= last_rev_in;
         acc_ff      <= acc_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         step_ff  <= step_in;
         moves_ff <= moves_in;
      end
   end

`ifndef ASSERT_OFF
   a_read_clears: assert property (@(posedge clock) disable iff (reset)
      advance && (op_ff == qenc_pkg::OP_READ) |=> acc_ff == '0)
      else $error("count not cleared after read");

   a_sample_no_moves: assert property (@(posedge clock) disable iff (reset)
      advance && (op_ff == qenc_pkg::OP_SAMPLE) |=> rsp_valid_ff && (moves_ff == '0))
      else $error("sample response carries a count");

   a_unprimed_no_step: assert property (@(posedge clock) disable iff (reset)
      advance && !pins_ff.primed |=> step_ff == qenc_pkg::DIR_NONE)
      else $error("step reported before first sample");

   a_state_held: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(pins_ff) && $stable(acc_ff))
      else $error("encoder state changed without a transfer");
`endif

endmodule

// ===== test/quadrature_encoder_step_counter_unit_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// quadrature_encoder_step_counter_unit_tb
// drives pin samples and count reads through the request channel, predicts
// each response with a cycle-free encoder model and checks every response
// transfer in order; covers debounce, hold-off, saturation and register writes
// ----------------------------------------------------------------------------
module quadrature_encoder_step_counter_unit_tb;
   import qenc_pkg::*;

   localparam int CYCLE_LIMIT = 200000;
   localparam int COUNT_CAP   = 2 ** (COUNT_BITS_DEFAULT - 1) - 1;

   typedef struct packed {
      logic                         operation;
      logic                         pin_a;
      logic                         pin_b;
      logic [TIME_BITS_DEFAULT-1:0] now_time;
   } encoder_item_type;

   typedef struct packed {
      logic [1:0]                    step_taken;
      logic [COUNT_BITS_DEFAULT-1:0] moves;
   } encoder_report_type;

   logic clock;
   logic reset;

   qenc_req_if req_if ();
   qenc_rsp_if rsp_if ();
   qenc_csr_if csr_if ();

   quadrature_encoder_step_counter_unit dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if),
      .csr_chan (csr_if)
   );

   // encoder model state
   cfg_type                              live_cfg;
   logic                                 seen_first;
   logic                                 held_a;
   logic                                 held_b;
   logic [DEBOUNCE_BITS-1:0]             bounce_a;
   logic [DEBOUNCE_BITS-1:0]             bounce_b;
   logic [TIME_BITS_DEFAULT-1:0]         fwd_stamp;
   logic [TIME_BITS_DEFAULT-1:0]         rev_stamp;
   logic signed [COUNT_BITS_DEFAULT-1:0] detent_total;

   encoder_item_type   pending_items[$];
   encoder_report_type due_reports[$];
   encoder_item_type   in_flight;
   encoder_report_type oldest_report;

   int   items_queued;
   int   items_taken;
   int   error_count;
   int   cycle_count;
   int   reads_seen;
   int   forward_seen;
   int   reverse_seen;
   int   clamp_seen;
   int   writes_done;
   bit   steady;
   logic [TIME_BITS_DEFAULT-1:0] wheel_time;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic encoder_report_type predict_report(input encoder_item_type it);
      encoder_report_type rep;
      int                 tally;
      rep.step_taken = DIR_NONE;
      rep.moves      = '0;
      if (it.operation == OP_READ) begin
         rep.moves    = detent_total;
         detent_total = '0;
         return rep;
      end
      if (!seen_first) begin
         seen_first = 1'b1;
         held_a     = it.pin_a;
         held_b     = it.pin_b;
         return rep;
      end
      if (held_a != it.pin_a) begin
         bounce_a = bounce_a + 1'b1;
         if (bounce_a >= live_cfg.debounce_count) begin
            bounce_a = '0;
            held_a   = it.pin_a;
            if (it.pin_a == it.pin_b &&
                (it.now_time - rev_stamp) >= live_cfg.reverse_holdoff) begin
               rep.step_taken = DIR_FORWARD;
               fwd_stamp      = it.now_time;
            end
         end
      end else begin
         bounce_a = '0;
      end
      // channel b checks against the forward time just updated by channel a
      if (held_b != it.pin_b) begin
         bounce_b = bounce_b + 1'b1;
         if (bounce_b > live_cfg.debounce_count) begin
            bounce_b = '0;
            held_b   = it.pin_b;
            if (it.pin_a == it.pin_b &&
                (it.now_time - fwd_stamp) >= live_cfg.reverse_holdoff) begin
               rep.step_taken = DIR_REVERSE;
               rev_stamp      = it.now_time;
            end
         end
      end else begin
         bounce_b = '0;
      end
      if (rep.step_taken != DIR_NONE) begin
         tally = int'(detent_total);
         if (rep.step_taken == DIR_FORWARD) begin
            tally = tally + int'(live_cfg.step_size);
         end else begin
            tally = tally - int'(live_cfg.step_size);
         end
         if (tally > COUNT_CAP) tally = COUNT_CAP;
         if (tally < -COUNT_CAP) tally = -COUNT_CAP;
         detent_total = tally[COUNT_BITS_DEFAULT-1:0];
      end
      return rep;
   endfunction

   task automatic flag_mismatch(input string field, input int want, input int got);
      error_count++;
      if (error_count <= 10) begin
         $display("mismatch on %s: expected %0d, got %0d", field, want, got);
      end
   endtask

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
      end else begin
         if (req_if.valid && req_if.ready) begin
            due_reports.push_back(predict_report(in_flight));
            items_taken++;
         end
         if (!req_if.valid || req_if.ready) begin
            if (pending_items.size() != 0 && (steady || $urandom_range(99) >= 24)) begin
               in_flight = pending_items.pop_front();
               req_if.valid     <= 1'b1;
               req_if.operation <= in_flight.operation;
               req_if.pin_a     <= in_flight.pin_a;
               req_if.pin_b     <= in_flight.pin_b;
               req_if.now_time  <= in_flight.now_time;
            end else begin
               req_if.valid <= 1'b0;
            end
         end
      end
   end

   // response monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            if (due_reports.size() == 0) begin
               error_count++;
               if (error_count <= 10) begin
                  $display("unexpected transfer: step_taken %0d moves %0d",
                           rsp_if.step_taken, rsp_if.moves);
               end
            end else begin
               oldest_report = due_reports.pop_front();
               if (oldest_report.step_taken !== rsp_if.step_taken) begin
                  flag_mismatch("step_taken", int'($signed(oldest_report.step_taken)),
                                int'(rsp_if.step_taken));
               end
               if (oldest_report.moves !== rsp_if.moves) begin
                  flag_mismatch("moves", int'($signed(oldest_report.moves)),
                                int'(rsp_if.moves));
               end
               if (oldest_report.step_taken == DIR_FORWARD) forward_seen++;
               if (oldest_report.step_taken == DIR_REVERSE) reverse_seen++;
               if ($signed(oldest_report.moves) == COUNT_CAP ||
                   $signed(oldest_report.moves) == -COUNT_CAP) begin
                  clamp_seen++;
               end
            end
         end
         rsp_if.ready <= steady || ($urandom_range(99) >= 24);
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("quadrature_encoder_step_counter_unit_tb: errors");
         $finish;
      end
   end

   task automatic push_sample(input logic a, input logic b,
                              input logic [TIME_BITS_DEFAULT-1:0] t);
      encoder_item_type it;
      it.operation = OP_SAMPLE;
      it.pin_a     = a;
      it.pin_b     = b;
      it.now_time  = t;
      pending_items.push_back(it);
      items_queued++;
   endtask

   task automatic push_read();
      encoder_item_type it;
      it.operation = OP_READ;
      it.pin_a     = 1'($urandom_range(1));
      it.pin_b     = 1'($urandom_range(1));
      it.now_time  = $urandom();
      pending_items.push_back(it);
      items_queued++;
      reads_seen++;
   endtask

   task automatic settle();
      while (items_taken != items_queued || due_reports.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_BITS-1:0] idx,
                            input logic [CSR_DATA_BITS-1:0] value);
      @(posedge clock);
      csr_if.valid <= 1'b1;
      csr_if.index <= idx;
      csr_if.data  <= value;
      @(posedge clock);
      while (!csr_if.ready) @(posedge clock);
      case (idx)
         REG_DEBOUNCE_COUNT:  live_cfg.debounce_count  = value[DEBOUNCE_BITS-1:0];
         REG_REVERSE_HOLDOFF: live_cfg.reverse_holdoff = value[HOLDOFF_BITS-1:0];
         REG_STEP_SIZE:       live_cfg.step_size       = value[STEP_BITS-1:0];
         default: ;
      endcase
      writes_done++;
      csr_if.valid <= 1'b0;
   endtask

   task automatic apply_cfg(input logic [DEBOUNCE_BITS-1:0] deb,
                            input logic [HOLDOFF_BITS-1:0] hold,
                            input logic [STEP_BITS-1:0] step, input bit junk);
      settle();
      write_reg(REG_DEBOUNCE_COUNT, {junk ? 24'($urandom()) : 24'd0, deb});
      write_reg(REG_REVERSE_HOLDOFF, hold);
      write_reg(REG_STEP_SIZE, {junk ? 25'($urandom()) : 25'd0, step});
   endtask

   // alternating both-pin toggles: one step per sample with debounce 0
   task automatic queue_pinwheel(input int count);
      int k;
      for (k = 0; k < count; k++) begin
         push_sample(k[0], k[0], wheel_time);
         wheel_time += $urandom_range(1, 5);
      end
   endtask

   task automatic queue_spin(input int budget);
      int         left;
      int         roll;
      int         hold;
      int         span;
      int         k;
      int         j;
      bit         fwd;
      logic [1:0] quad_pos;
      logic [1:0] lv;
      logic [1:0] prev;
      left     = budget;
      quad_pos = {held_a, held_a ^ held_b};
      while (left > 0) begin
         roll = $urandom_range(99);
         if (roll < 8) begin
            push_read();
            left--;
         end else if (roll < 20) begin
            push_sample(1'($urandom_range(1)), 1'($urandom_range(1)), $urandom());
            left--;
         end else begin
            fwd  = 1'($urandom_range(1));
            span = $urandom_range(1, 4);
            for (k = 0; k < span; k++) begin
               prev     = quad_pos ^ (quad_pos >> 1);
               quad_pos = fwd ? quad_pos + 2'd1 : quad_pos - 2'd1;
               lv       = quad_pos ^ (quad_pos >> 1);
               hold     = int'(live_cfg.debounce_count) + 1 + $urandom_range(0, 2);
               for (j = 0; j < hold; j++) begin
                  // contact bounce back to the previous level
                  if ($urandom_range(99) < 6) begin
                     push_sample(prev[1], prev[0], wheel_time);
                  end else begin
                     push_sample(lv[1], lv[0], wheel_time);
                  end
                  wheel_time += $urandom_range(1, 60);
                  left--;
               end
            end
         end
      end
   endtask

   initial begin : stimulus
      int   ph;
      logic far_a;
      logic far_b;
      clock            = 1'b0;
      reset            = 1'b1;
      req_if.valid     = 1'b0;
      req_if.operation = OP_SAMPLE;
      req_if.pin_a     = 1'b0;
      req_if.pin_b     = 1'b0;
      req_if.now_time  = '0;
      rsp_if.ready     = 1'b0;
      csr_if.valid     = 1'b0;
      csr_if.index     = REG_DEBOUNCE_COUNT;
      csr_if.data      = '0;
      live_cfg         = '{DEBOUNCE_RESET, HOLDOFF_RESET, STEP_RESET};
      seen_first       = 1'b0;
      held_a           = 1'b0;
      held_b           = 1'b0;
      bounce_a         = '0;
      bounce_b         = '0;
      fwd_stamp        = '0;
      rev_stamp        = '0;
      detent_total     = '0;
      items_queued     = 0;
      items_taken      = 0;
      error_count      = 0;
      cycle_count      = 0;
      reads_seen       = 0;
      forward_seen     = 0;
      reverse_seen     = 0;
      clamp_seen       = 0;
      writes_done      = 0;
      steady           = 1'b0;
      wheel_time       = '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // reset settings: priming, debounce, hold-off and time wrap
      push_read();
      push_sample(1'b1, 1'b1, 32'd0);
      push_sample(1'b0, 1'b1, 32'd5);
      push_sample(1'b0, 1'b0, 32'd10);
      push_sample(1'b0, 1'b0, 32'd20);
      push_sample(1'b1, 1'b0, 32'd300);
      push_sample(1'b1, 1'b1, 32'd310);
      push_sample(1'b1, 1'b1, 32'd320);
      push_sample(1'b0, 1'b1, 32'd330);
      push_sample(1'b1, 1'b1, 32'd340);
      push_sample(1'b0, 1'b1, 32'd500);
      push_sample(1'b1, 1'b1, 32'd510);
      push_sample(1'b1, 1'b0, 32'hFFFF_FF00);
      push_sample(1'b1, 1'b0, 32'hFFFF_FF10);
      push_sample(1'b1, 1'b1, 32'hFFFF_FFF0);
      push_sample(1'b1, 1'b1, 32'hFFFF_FFF8);
      push_sample(1'b0, 1'b1, 32'hFFFF_FFFF);
      push_sample(1'b1, 1'b1, 32'h0000_0010);
      push_read();

      // debounce zero, no hold-off: simultaneous commits, then zero step size
      apply_cfg(8'd0, 32'd0, 7'd127, 1'b0);
      push_sample(1'b0, 1'b0, 32'd1000);
      push_sample(1'b1, 1'b0, 32'd1001);
      push_sample(1'b1, 1'b1, 32'd1002);
      push_read();
      apply_cfg(8'd0, 32'd0, 7'd0, 1'b0);
      push_sample(1'b0, 1'b1, 32'd1010);
      push_sample(1'b0, 1'b0, 32'd1011);
      push_read();

      // saturation both ways, no idling on either side
      steady = 1'b1;
      wheel_time = $urandom();
      apply_cfg(8'd0, 32'd1, 7'd127, 1'b0);
      push_read();
      queue_pinwheel(280);
      push_read();
      apply_cfg(8'd0, 32'd0, 7'd127, 1'b0);
      queue_pinwheel(280);
      push_read();

      // widest debounce: channel b mismatch count wraps and never commits
      apply_cfg(8'd255, $urandom(), 7'($urandom_range(1, 127)), 1'b0);
      far_a = !held_a;
      far_b = !held_b;
      repeat (258) begin
         push_sample(far_a, far_b, wheel_time);
         wheel_time += $urandom_range(1, 60);
      end
      push_read();
      settle();
      steady = 1'b0;

      for (ph = 0; ph < 6; ph++) begin
         case (ph)
            0: apply_cfg(8'd1, 32'd100, 7'd1, 1'b1);
            1: apply_cfg(8'd0, 32'd0, 7'd127, 1'b1);
            2: apply_cfg(8'd2, 32'hFFFF_FFFF, 7'($urandom_range(1, 127)), 1'b1);
            3: apply_cfg(8'($urandom_range(0, 4)), $urandom_range(0, 300),
                         7'($urandom_range(1, 127)), 1'b1);
            4: apply_cfg(8'd3, $urandom(), 7'd1, 1'b0);
            default: apply_cfg(8'($urandom_range(0, 6)), $urandom_range(0, 60),
                               7'($urandom_range(1, 127)), 1'b0);
         endcase
         queue_spin(150);
      end

      settle();
      repeat (8) @(posedge clock);
      $display("%0d requests sent, %0d of them reads; %0d forward, %0d reverse steps",
               items_queued, reads_seen, forward_seen, reverse_seen);
      $display("%0d reads at the count limit, %0d register writes",
               clamp_seen, writes_done);
      if (error_count == 0) begin
         $display("quadrature_encoder_step_counter_unit_tb: clean");
      end else begin
         $display("quadrature_encoder_step_counter_unit_tb: errors");
      end
      $finish;
   end

endmodule
